FILE: hdl/pcf_pkg.sv
// types, codes and constants of the pitch complementary filter
// atan table for the cordic and a 32-bit saturation helper; no dependencies

package pcf_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MOP_RATE,
        MOP_DT,
        MOP_BLEND,
        MOP_GAIN
    } t_mul_op;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_LSB_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET   = 3'd4;

    localparam logic [15:0] ACC_LOW_MASK = 16'hFFF0;

    localparam int ATAN_LEN  = 24;
    localparam int ACC_W     = 42;
    localparam int XY_W      = 36;
    localparam int MUL_BITS  = 18;
    localparam int PROD_W    = 52;
    localparam int WIDE_W    = 40;

    localparam logic signed [ACC_W-1:0] HALF_TURN = 42'sd773094113280;

    // atan(2^-i) in degrees, 32 fraction bits
    function automatic logic signed [ACC_W-1:0] atan_deg(input logic [4:0] idx);
        logic signed [ACC_W-1:0] v;
        unique case (idx)
            5'd0:    v = 42'sd193273528320;
            5'd1:    v = 42'sd114096026024;
            5'd2:    v = 42'sd60285206652;
            5'd3:    v = 42'sd30601712202;
            5'd4:    v = 42'sd15360239180;
            5'd5:    v = 42'sd7687607525;
            5'd6:    v = 42'sd3844741810;
            5'd7:    v = 42'sd1922488225;
            5'd8:    v = 42'sd961258780;
            5'd9:    v = 42'sd480631223;
            5'd10:   v = 42'sd240315841;
            5'd11:   v = 42'sd120157949;
            5'd12:   v = 42'sd60078978;
            5'd13:   v = 42'sd30039489;
            5'd14:   v = 42'sd15019745;
            5'd15:   v = 42'sd7509872;
            5'd16:   v = 42'sd3754936;
            5'd17:   v = 42'sd1877468;
            5'd18:   v = 42'sd938734;
            5'd19:   v = 42'sd469367;
            5'd20:   v = 42'sd234684;
            5'd21:   v = 42'sd117342;
            5'd22:   v = 42'sd58671;
            5'd23:   v = 42'sd29335;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/pitch_complementary_filter_unit.sv
// pitch complementary filter: top level with cordic and serial multiplier
// depends on pcf_pkg

// One sample tick in, one pitch angle and rate out. An item runs
// N = min(CORDIC_ITERATIONS, 24) steps of the iterative cordic atan2
// (one micro-rotation a cycle), then four products on one shared
// shift-and-add multiplier that retires one multiplier bit a cycle
// (18 bits each, then a rounding step).
// The block takes one item at a time; a finished result waits in the output
// register while the next item is accepted. Configuration writes are taken
// in any cycle and must only happen while the block is idle.
module pitch_complementary_filter_unit #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int FRAC_BITS         = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [15:0]                i_accel_x_word,
    input  logic signed [15:0]                i_accel_z_word,
    input  logic signed [15:0]                i_gyro_y_word,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [31:0]                o_pitch_angle,
    output logic signed [31:0]                o_pitch_rate,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pcf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int NITER  = (CORDIC_ITERATIONS > pcf_pkg::ATAN_LEN) ?
                            pcf_pkg::ATAN_LEN : CORDIC_ITERATIONS;
    localparam int ACC_SH = 32 - FRAC_BITS;
    localparam int LSH    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int RSH    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic signed [pcf_pkg::WIDE_W-1:0] RATE_RND = (40'sd1 <<< RSH) >>> 1;
    localparam logic signed [pcf_pkg::ACC_W-1:0]  ACC_RND  = 42'sd1 <<< (ACC_SH - 1);
    localparam logic signed [pcf_pkg::PROD_W-1:0] HALF_LSB = 52'sd32768;

    pcf_pkg::t_state  r_state, n_state;
    pcf_pkg::t_mul_op r_mop;

    logic signed [pcf_pkg::XY_W-1:0]   r_x, r_y, n_x, n_y;
    logic signed [pcf_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic                              r_zero;
    logic [4:0]                        r_iter;
    logic signed [15:0]                r_gy;

    logic signed [pcf_pkg::PROD_W-1:0] r_prod, r_mcand, n_prod;
    logic [pcf_pkg::MUL_BITS-1:0]      r_mlr;
    logic [4:0]                        r_mcnt;

    logic signed [31:0]                r_rate, r_angle;
    logic signed [35:0]                r_t2;

    logic [16:0]                       r_gain;
    logic [15:0]                       r_scale, r_period;
    logic signed [24:0]                r_goff, r_aoff;

    logic                              r_ovalid;
    logic signed [31:0]                r_out_angle, r_out_rate;

    logic                              in_accept, out_free, mul_last;
    logic signed [15:0]                ax, az;
    logic signed [pcf_pkg::XY_W-1:0]   ax_w, az_w;
    logic signed [pcf_pkg::XY_W-1:0]   dx, dy;
    logic signed [pcf_pkg::ACC_W-1:0]  at, acc_rnd;
    logic signed [33:0]                accp, diff;
    logic signed [pcf_pkg::PROD_W-1:0] addend, prod_rnd;
    logic signed [35:0]                q;
    logic signed [pcf_pkg::WIDE_W-1:0] rate_w;
    logic signed [31:0]                rate_sat;
    logic [pcf_pkg::MUL_BITS-1:0]      one_minus_k;

    // input conditioning and cordic micro-rotation
    always_comb begin
        ax    = signed'(i_accel_x_word & pcf_pkg::ACC_LOW_MASK);
        az    = signed'(i_accel_z_word & pcf_pkg::ACC_LOW_MASK);
        ax_w  = pcf_pkg::XY_W'(ax) <<< 16;
        az_w  = pcf_pkg::XY_W'(az) <<< 16;
        dx    = r_y >>> r_iter;
        dy    = r_x >>> r_iter;
        at    = pcf_pkg::atan_deg(r_iter);
        if (!r_y[pcf_pkg::XY_W-1]) begin
            n_x   = r_x + dx;
            n_y   = r_y - dy;
            n_acc = r_acc + at;
        end else begin
            n_x   = r_x - dx;
            n_y   = r_y + dy;
            n_acc = r_acc - at;
        end
        acc_rnd = (r_acc + ACC_RND) >>> ACC_SH;
        accp    = r_zero ? 34'sd0 : 34'(acc_rnd);
        diff    = accp - 34'(r_angle);
    end

    // serial multiplier step and rounding of the finished product
    always_comb begin
        mul_last = (r_mcnt == 5'(pcf_pkg::MUL_BITS - 1));
        if (r_mlr[0]) begin
            addend = mul_last ? -r_mcand : r_mcand;
        end else begin
            addend = '0;
        end
        n_prod      = r_prod + addend;
        prod_rnd    = (r_prod + HALF_LSB) >>> 16;
        q           = 36'(prod_rnd);
        rate_w      = (((pcf_pkg::WIDE_W'(r_prod) <<< LSH) + RATE_RND) >>> RSH)
                      - pcf_pkg::WIDE_W'(r_goff);
        rate_sat    = pcf_pkg::sat32(rate_w);
        one_minus_k = 18'h10000 - {1'b0, r_gain};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcf_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = pcf_pkg::ST_CORDIC;
                end
            end
            pcf_pkg::ST_CORDIC: begin
                if (r_iter == 5'(NITER - 1)) begin
                    n_state = pcf_pkg::ST_MUL;
                end
            end
            pcf_pkg::ST_MUL: begin
                if (r_mcnt == 5'(pcf_pkg::MUL_BITS) && r_mop == pcf_pkg::MOP_GAIN) begin
                    n_state = pcf_pkg::ST_DONE;
                end
            end
            pcf_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = pcf_pkg::ST_IDLE;
                end
            end
            default: n_state = pcf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall       = (r_state != pcf_pkg::ST_IDLE);
        o_cfg_ready   = 1'b1;
        o_valid       = r_ovalid;
        o_pitch_angle = r_out_angle;
        o_pitch_rate  = r_out_rate;
        in_accept     = i_valid && !o_stall;
        out_free      = !r_ovalid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pcf_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_mcnt   <= '0;
            r_angle  <= '0;
            r_gain   <= 17'd328;
            r_scale  <= 16'd498;
            r_period <= 16'd328;
            r_goff   <= '0;
            r_aoff   <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pcf_pkg::CFG_FILTER_GAIN:    r_gain   <= i_cfg_data[16:0];
                    pcf_pkg::CFG_GYRO_LSB_SCALE: r_scale  <= i_cfg_data[15:0];
                    pcf_pkg::CFG_SAMPLE_PERIOD:  r_period <= i_cfg_data[15:0];
                    pcf_pkg::CFG_GYRO_OFFSET:    r_goff   <= signed'(i_cfg_data);
                    pcf_pkg::CFG_ANGLE_OFFSET:   r_aoff   <= signed'(i_cfg_data);
                    default: ;
                endcase
            end

            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                pcf_pkg::ST_IDLE: begin
                    if (in_accept) begin
                        r_gy   <= i_gyro_y_word;
                        r_iter <= '0;
                        r_zero <= (ax == 16'sd0) && (az == 16'sd0);
                        if (az < 16'sd0) begin
                            r_x   <= -az_w;
                            r_y   <= -ax_w;
                            r_acc <= (ax >= 16'sd0) ? pcf_pkg::HALF_TURN : -pcf_pkg::HALF_TURN;
                        end else begin
                            r_x   <= az_w;
                            r_y   <= ax_w;
                            r_acc <= '0;
                        end
                    end
                end
                pcf_pkg::ST_CORDIC: begin
                    r_x    <= n_x;
                    r_y    <= n_y;
                    r_acc  <= n_acc;
                    r_iter <= r_iter + 5'd1;
                    if (r_iter == 5'(NITER - 1)) begin
                        r_mop   <= pcf_pkg::MOP_RATE;
                        r_mcand <= -pcf_pkg::PROD_W'(r_gy);
                        r_mlr   <= {2'b00, r_scale};
                        r_prod  <= '0;
                        r_mcnt  <= '0;
                    end
                end
                pcf_pkg::ST_MUL: begin
                    if (r_mcnt != 5'(pcf_pkg::MUL_BITS)) begin
                        r_prod  <= n_prod;
                        r_mcand <= r_mcand <<< 1;
                        r_mlr   <= r_mlr >> 1;
                        r_mcnt  <= r_mcnt + 5'd1;
                    end else begin
                        r_prod <= '0;
                        r_mcnt <= '0;
                        unique case (r_mop)
                            pcf_pkg::MOP_RATE: begin
                                r_rate  <= rate_sat;
                                r_mcand <= pcf_pkg::PROD_W'(rate_sat);
                                r_mlr   <= {2'b00, r_period};
                                r_mop   <= pcf_pkg::MOP_DT;
                            end
                            pcf_pkg::MOP_DT: begin
                                r_mcand <= pcf_pkg::PROD_W'(q);
                                r_mlr   <= one_minus_k;
                                r_mop   <= pcf_pkg::MOP_BLEND;
                            end
                            pcf_pkg::MOP_BLEND: begin
                                r_t2    <= q;
                                r_mcand <= pcf_pkg::PROD_W'(diff);
                                r_mlr   <= {1'b0, r_gain};
                                r_mop   <= pcf_pkg::MOP_GAIN;
                            end
                            pcf_pkg::MOP_GAIN: begin
                                r_angle <= pcf_pkg::sat32(pcf_pkg::WIDE_W'(r_angle)
                                           + pcf_pkg::WIDE_W'(q) + pcf_pkg::WIDE_W'(r_t2));
                            end
                            default: ;
                        endcase
                    end
                end
                pcf_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_ovalid    <= 1'b1;
                        r_out_rate  <= r_rate;
                        r_out_angle <= pcf_pkg::sat32(pcf_pkg::WIDE_W'(r_angle)
                                       + pcf_pkg::WIDE_W'(r_aoff));
                    end
                end
                default: ;
            endcase
        end
    end

    a_mcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcnt <= 5'(pcf_pkg::MUL_BITS))
        else $error("multiplier bit counter out of range");

    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcf_pkg::ST_CORDIC) |-> (r_iter < 5'(NITER)))
        else $error("cordic iteration beyond table");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == pcf_pkg::ST_DONE))
        else $error("result raised outside completion");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == pcf_pkg::ST_CORDIC))
        else $error("accepted transfer did not start the cordic");

endmodule
